/* hdl/sba_pkg.sv */
// ---------------------------------------------------------------------------
// sba_pkg - slab bitmap allocator shared definitions
// Slab geometry, field widths, status codes and the object count helper.
// ---------------------------------------------------------------------------
package sba_pkg;

    localparam int SLAB_BYTES   = 4096;
    localparam int MAX_OBJECTS  = 256;

    localparam int ADDR_W       = 48;
    localparam int CLASS_W      = 3;
    localparam int STATUS_W     = 2;
    localparam int IDX_W        = $clog2(MAX_OBJECTS);
    localparam int COUNT_W      = $clog2(MAX_OBJECTS + 1);
    localparam int SHIFT_W      = 4;
    localparam int MIN_SHIFT    = 4;

    // bitmap is scanned one word per cycle
    localparam int WORD_BITS    = 32;
    localparam int BIT_SEL_W    = $clog2(WORD_BITS);
    localparam int NUM_WORDS    = MAX_OBJECTS / WORD_BITS;
    localparam int WORD_SEL_W   = IDX_W - BIT_SEL_W;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DOUBLE = 2'd3;

    localparam logic CFG_SIZE_CLASS = 1'b0;
    localparam logic CFG_BASE_ADDR  = 1'b1;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // live objects for a size class, capped at the bitmap depth
    function automatic logic [COUNT_W-1:0] obj_count(input logic [CLASS_W-1:0] sc);
        int v;
        v = SLAB_BYTES >> (MIN_SHIFT + int'(sc));
        if (v > MAX_OBJECTS)
        begin
            v = MAX_OBJECTS;
        end
        return COUNT_W'(v);
    endfunction

endpackage

/* hdl/slab_bitmap_allocator.sv */
// ---------------------------------------------------------------------------
// slab_bitmap_allocator - one slab of fixed-size objects
// Occupancy bitmap allocator: allocate takes the lowest clear bit, free
// turns an address back into an index and clears its bit.
// ---------------------------------------------------------------------------
//
//  channel   handshake                    payload
//  -------   ---------------------------  ----------------------------------
//  request   start & !busy                mode, address
//  result    done (one cycle, no stall)   status, object_address,
//                                         object_index, free_count
//  config    cfg_valid & cfg_ready        cfg_index, cfg_data
//
//  Allocate: scans bitmap words in order (up to 8 at 256 objects) until
//  one has a live clear bit, then forms the address; a full slab scans
//  every live word and skips the address step. Each scan step is the
//  single 32-bit word read/priority-encode. Free: subtract, shift/compare
//  and bit test, the subtract through the shared 49-bit adder; an out of
//  range address ends after the compare. One request at a time; busy stays
//  high until done. Reset clears the bitmap, the used count and config at
//  once (flip-flop bitmap, no clearing pass). The receiver cannot stall.
//
module slab_bitmap_allocator
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            start,
    output logic                            busy,
    input  logic                            mode,
    input  logic [sba_pkg::ADDR_W-1:0]      address,

    output logic                            done,
    output logic [sba_pkg::STATUS_W-1:0]    status,
    output logic [sba_pkg::ADDR_W-1:0]      object_address,
    output logic [sba_pkg::IDX_W-1:0]       object_index,
    output logic [sba_pkg::COUNT_W-1:0]     free_count,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [sba_pkg::ADDR_W-1:0]      cfg_data
);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;   // alloc: one bitmap word per cycle
    localparam logic [2:0] S_ADDR   = 3'd2;   // alloc: base + idx << shift
    localparam logic [2:0] S_SUB    = 3'd3;   // free: address - base
    localparam logic [2:0] S_CHK    = 3'd4;   // free: shift and range check
    localparam logic [2:0] S_TEST   = 3'd5;   // free: test bit, clear it if set
    localparam logic [2:0] S_FINISH = 3'd6;   // latch result

    // config
    logic [sba_pkg::CLASS_W-1:0]            size_class_reg;
    logic [sba_pkg::ADDR_W-1:0]             base_reg;

    // control
    logic [2:0]                             state_reg, state_next;
    logic                                   done_reg, done_next;
    logic [sba_pkg::COUNT_W-1:0]            used_reg, used_next;

    // occupancy bitmap, word organized
    logic [sba_pkg::WORD_BITS-1:0]          occ_reg [sba_pkg::NUM_WORDS];
    logic                                   occ_we;
    logic                                   occ_wval;

    // per-request working registers
    logic [sba_pkg::ADDR_W-1:0]             addr_reg, addr_next;
    logic [sba_pkg::COUNT_W-1:0]            n_reg, n_next;
    logic [sba_pkg::SHIFT_W-1:0]            shift_reg, shift_next;
    logic [sba_pkg::WORD_SEL_W-1:0]         word_reg, word_next;
    logic [sba_pkg::IDX_W-1:0]              idx_reg, idx_next;
    logic [sba_pkg::STATUS_W-1:0]           st_reg, st_next;
    logic [sba_pkg::ADDR_W-1:0]             oaddr_reg, oaddr_next;
    logic [sba_pkg::ADDR_W-1:0]             diff_reg, diff_next;
    logic                                   borrow_reg, borrow_next;

    // output registers
    logic [sba_pkg::STATUS_W-1:0]           status_reg, status_next;
    logic [sba_pkg::ADDR_W-1:0]             obj_addr_reg, obj_addr_next;
    logic [sba_pkg::IDX_W-1:0]              obj_idx_reg, obj_idx_next;
    logic [sba_pkg::COUNT_W-1:0]            free_reg, free_next;

    // shared adder
    logic [sba_pkg::ADDR_W-1:0]             add_a, add_b;
    logic                                   add_cin;
    logic [sba_pkg::ADDR_W:0]               add_sum;

    // scan datapath
    logic [sba_pkg::WORD_BITS-1:0]          cur_word;
    logic [sba_pkg::WORD_BITS-1:0]          live_mask;
    logic [sba_pkg::WORD_BITS-1:0]          clr_bits;
    logic [sba_pkg::BIT_SEL_W-1:0]          clr_pos;
    logic [sba_pkg::COUNT_W-1:0]            n_minus1;
    logic [sba_pkg::WORD_SEL_W-1:0]         last_word;
    logic [sba_pkg::ADDR_W-1:0]             offset;

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign object_address = obj_addr_reg;
    assign object_index   = obj_idx_reg;
    assign free_count     = free_reg;
    assign cfg_ready      = 1'b1;

    // one bitmap word read, at word_reg only
    assign cur_word  = occ_reg[word_reg];
    // small slabs: only the low n bits of word 0 are live
    assign live_mask = (n_reg >= sba_pkg::COUNT_W'(sba_pkg::WORD_BITS)) ? '1 :
                       ((sba_pkg::WORD_BITS'(1) << n_reg[sba_pkg::BIT_SEL_W-1:0])
                        - sba_pkg::WORD_BITS'(1));
    assign clr_bits  = ~cur_word & live_mask;
    assign n_minus1  = n_reg - sba_pkg::COUNT_W'(1);
    assign last_word = n_minus1[sba_pkg::IDX_W-1:sba_pkg::BIT_SEL_W];
    assign offset    = diff_reg >> shift_reg;

    // lowest clear bit
    always_comb
    begin
        clr_pos = '0;
        for (int b = sba_pkg::WORD_BITS - 1; b >= 0; b--)
        begin
            if (clr_bits[b])
            begin
                clr_pos = sba_pkg::BIT_SEL_W'(b);
            end
        end
    end

    // adder operands: object address on alloc, address - base on free
    always_comb
    begin
        if (state_reg == S_ADDR)
        begin
            add_a   = base_reg;
            add_b   = sba_pkg::ADDR_W'(idx_reg) << shift_reg;
            add_cin = 1'b0;
        end
        else
        begin
            add_a   = addr_reg;
            add_b   = ~base_reg;
            add_cin = 1'b1;
        end
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{sba_pkg::ADDR_W{1'b0}}, add_cin};

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        used_next     = used_reg;
        occ_we        = 1'b0;
        occ_wval      = 1'b0;
        addr_next     = addr_reg;
        n_next        = n_reg;
        shift_next    = shift_reg;
        word_next     = word_reg;
        idx_next      = idx_reg;
        st_next       = st_reg;
        oaddr_next    = oaddr_reg;
        diff_next     = diff_reg;
        borrow_next   = borrow_reg;
        status_next   = status_reg;
        obj_addr_next = obj_addr_reg;
        obj_idx_next  = obj_idx_reg;
        free_next     = free_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    addr_next  = address;
                    n_next     = sba_pkg::obj_count(size_class_reg);
                    shift_next = sba_pkg::SHIFT_W'(sba_pkg::MIN_SHIFT)
                                 + sba_pkg::SHIFT_W'(size_class_reg);
                    word_next  = '0;
                    idx_next   = '0;
                    oaddr_next = '0;
                    st_next    = sba_pkg::ST_OK;
                    state_next = (mode == sba_pkg::MODE_FREE) ? S_SUB : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (clr_bits != '0)
                begin
                    idx_next   = {word_reg, clr_pos};
                    occ_we     = 1'b1;
                    occ_wval   = 1'b1;
                    used_next  = used_reg + sba_pkg::COUNT_W'(1);
                    state_next = S_ADDR;
                end
                else if (word_reg == last_word)
                begin
                    st_next    = sba_pkg::ST_FULL;
                    state_next = S_FINISH;
                end
                else
                begin
                    word_next  = word_reg + sba_pkg::WORD_SEL_W'(1);
                end
            end
            S_ADDR:
            begin
                oaddr_next = add_sum[sba_pkg::ADDR_W-1:0];
                state_next = S_FINISH;
            end
            S_SUB:
            begin
                diff_next   = add_sum[sba_pkg::ADDR_W-1:0];
                borrow_next = ~add_sum[sba_pkg::ADDR_W];
                state_next  = S_CHK;
            end
            S_CHK:
            begin
                if (borrow_reg || (offset >= sba_pkg::ADDR_W'(n_reg)))
                begin
                    st_next    = sba_pkg::ST_RANGE;
                    state_next = S_FINISH;
                end
                else
                begin
                    idx_next   = offset[sba_pkg::IDX_W-1:0];
                    word_next  = offset[sba_pkg::IDX_W-1:sba_pkg::BIT_SEL_W];
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (cur_word[idx_reg[sba_pkg::BIT_SEL_W-1:0]])
                begin
                    occ_we   = 1'b1;
                    occ_wval = 1'b0;
                    if (used_reg != '0)
                    begin
                        used_next = used_reg - sba_pkg::COUNT_W'(1);
                    end
                end
                else
                begin
                    // double free: report and leave the bitmap alone
                    st_next = sba_pkg::ST_DOUBLE;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                status_next   = st_reg;
                obj_addr_next = oaddr_reg;
                obj_idx_next  = idx_reg;
                free_next     = (n_reg > used_reg) ? (n_reg - used_reg) : '0;
                done_next     = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_reg       <= 1'b0;
            used_reg       <= '0;
            size_class_reg <= '0;
            base_reg       <= '0;
            for (int w = 0; w < sba_pkg::NUM_WORDS; w++)
            begin
                occ_reg[w] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            used_reg  <= used_next;
            if (occ_we)
            begin
                occ_reg[word_reg][idx_next[sba_pkg::BIT_SEL_W-1:0]] <= occ_wval;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == sba_pkg::CFG_SIZE_CLASS)
                begin
                    size_class_reg <= cfg_data[sba_pkg::CLASS_W-1:0];
                end
                else
                begin
                    base_reg <= cfg_data;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        n_reg        <= n_next;
        shift_reg    <= shift_next;
        word_reg     <= word_next;
        idx_reg      <= idx_next;
        st_reg       <= st_next;
        oaddr_reg    <= oaddr_next;
        diff_reg     <= diff_next;
        borrow_reg   <= borrow_next;
        status_reg   <= status_next;
        obj_addr_reg <= obj_addr_next;
        obj_idx_reg  <= obj_idx_next;
        free_reg     <= free_next;
    end

`ifndef SYNTH
    // a result follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a request in flight");

    // accepted request makes the block busy
    a_busy_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // full or range results carry no object
    a_no_object: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == sba_pkg::ST_FULL || status == sba_pkg::ST_RANGE))
        |-> (object_address == '0 && object_index == '0))
        else $error("object reported on a failed request");

    // used count never exceeds the bitmap depth
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= sba_pkg::COUNT_W'(sba_pkg::MAX_OBJECTS))
        else $error("used count overflow");

    // bitmap is only written while a request is in flight
    a_occ_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        occ_we |-> (busy && !done_next))
        else $error("bitmap write outside a request");
`endif

endmodule
